>>> rtl/core/mcma_pkg.sv
// Shared types and constants for the MIDI channel message assembler.
package mcma_pkg;

    localparam int DATA_W  = 7;
    localparam int CHAN_W  = 4;
    localparam int TYPE_W  = 5;
    localparam int NUM_W   = 15;
    localparam int SLOT_W  = 8;

    localparam logic [3:0] FN_OFF   = 4'h8;
    localparam logic [3:0] FN_ON    = 4'h9;
    localparam logic [3:0] FN_KEYP  = 4'hA;
    localparam logic [3:0] FN_CC    = 4'hB;
    localparam logic [3:0] FN_PROG  = 4'hC;
    localparam logic [3:0] FN_CHANP = 4'hD;
    localparam logic [3:0] FN_BEND  = 4'hE;
    localparam logic [3:0] FN_SYS   = 4'hF;

    localparam logic [3:0] SYS_SYSEX = 4'h0;
    localparam logic [3:0] SYS_SPP   = 4'h2;
    localparam logic [3:0] SYS_SSEL  = 4'h3;
    localparam logic [3:0] SYS_CLK   = 4'h8;
    localparam logic [3:0] SYS_START = 4'hA;
    localparam logic [3:0] SYS_CONT  = 4'hB;
    localparam logic [3:0] SYS_STOP  = 4'hC;
    localparam logic [3:0] SYS_RESET = 4'hF;

    localparam logic [TYPE_W-1:0] MT_ON     = 5'd0;
    localparam logic [TYPE_W-1:0] MT_OFF    = 5'd1;
    localparam logic [TYPE_W-1:0] MT_KEYP   = 5'd2;
    localparam logic [TYPE_W-1:0] MT_CC     = 5'd3;
    localparam logic [TYPE_W-1:0] MT_PROG   = 5'd4;
    localparam logic [TYPE_W-1:0] MT_CHANP  = 5'd5;
    localparam logic [TYPE_W-1:0] MT_BEND   = 5'd6;
    localparam logic [TYPE_W-1:0] MT_SYSEX  = 5'd7;
    localparam logic [TYPE_W-1:0] MT_SPP    = 5'd8;
    localparam logic [TYPE_W-1:0] MT_SSEL   = 5'd9;
    localparam logic [TYPE_W-1:0] MT_CLK    = 5'd10;
    localparam logic [TYPE_W-1:0] MT_START  = 5'd11;
    localparam logic [TYPE_W-1:0] MT_CONT   = 5'd12;
    localparam logic [TYPE_W-1:0] MT_STOP   = 5'd13;
    localparam logic [TYPE_W-1:0] MT_RESET  = 5'd14;
    localparam logic [TYPE_W-1:0] MT_RPN    = 5'd15;
    localparam logic [TYPE_W-1:0] MT_NRPN   = 5'd16;
    localparam logic [TYPE_W-1:0] MT_CC14   = 5'd17;

    localparam logic [DATA_W-1:0] CC_DATA_MSB = 7'd6;
    localparam logic [DATA_W-1:0] CC_DATA_LSB = 7'd38;
    localparam logic [DATA_W-1:0] CC_NRPN_LSB = 7'd98;
    localparam logic [DATA_W-1:0] CC_NRPN_MSB = 7'd99;
    localparam logic [DATA_W-1:0] CC_RPN_LSB  = 7'd100;
    localparam logic [DATA_W-1:0] CC_RPN_MSB  = 7'd101;
    localparam logic [DATA_W-1:0] CC_LSB_BASE = 7'd32;
    localparam logic [DATA_W-1:0] CC_LSB_END  = 7'd64;
    localparam logic [DATA_W-1:0] DATA_MAX    = 7'd127;

    localparam logic [NUM_W-1:0]  NUM_NONE  = 15'h7FFF;
    localparam logic [SLOT_W-1:0] SLOT_NONE = 8'hFF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic              is_cc;
        logic [TYPE_W-1:0] msg_type;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] data_one;
        logic [DATA_W-1:0] data_two;
        logic [NUM_W-1:0]  extra_value;
    } cmd_t;

    typedef struct packed {
        logic [TYPE_W-1:0] msg_type;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] data_one;
        logic [DATA_W-1:0] data_two;
        logic [NUM_W-1:0]  param_number;
        logic [NUM_W-1:0]  extra_value;
        logic              is_component;
    } res_t;

endpackage

>>> rtl/core/midi_channel_message_assembler.sv
// Top level: MIDI channel message assembler with stream ports.
// After reset a clearing pass empties all 2**(clog2(NUM_CHANNELS)+clog2(NUM_PAIRED_CC))
// entries (512 by default) of the pair store; s_tready stays low meanwhile.
// The first result passes the front-end queue slot, then the back-end command, result
// and output registers. Each message gives n results (1 to 3), sent after the pair-store
// read one per cycle while m_tready allows; the back end then takes the next message.
// Reset (aresetn low, synchronous) empties the queue, output and all controller state.
module midi_channel_message_assembler #(
    parameter int NUM_CHANNELS  = 16,
    parameter int NUM_PAIRED_CC = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // chan, data_one, data_two, zero pad
    input  logic [3:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_chan, out_data_one, out_data_two,
                                   // param_number, extra_value
    output logic [5:0]  m_tuser,   // msg_type, is_component
    output logic        m_tlast
);
    import mcma_pkg::*;

    logic   clear_busy;
    logic   q_valid;
    logic   q_ready;
    cmd_t   q_cmd;
    res_t   res;

    mcma_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_busy (clear_busy),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_chan    (s_tdata[3:0]),
        .in_data_one(s_tdata[10:4]),
        .in_data_two(s_tdata[17:11]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd)
    );

    mcma_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_PAIRED_CC(NUM_PAIRED_CC)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear_busy(clear_busy),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {res.extra_value, res.param_number, res.data_two,
                      res.data_one, res.chan};
    assign m_tuser = {res.is_component, res.msg_type};

endmodule

>>> rtl/core/mcma_ram.sv
// Generic single write port RAM with registered read.
module mcma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mcma_front.sv
// Front end: accepts messages, classifies them and queues commands.
module mcma_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear_busy,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            in_func,
    input  logic [3:0]            in_chan,
    input  logic [6:0]            in_data_one,
    input  logic [6:0]            in_data_two,
    output logic                  q_valid,
    input  logic                  q_ready,
    output mcma_pkg::cmd_t        q_cmd
);
    import mcma_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb begin
        cls.is_cc       = 1'b0;
        cls.msg_type    = MT_ON;
        cls.chan        = in_chan;
        cls.data_one    = in_data_one;
        cls.data_two    = in_data_two;
        cls.extra_value = NUM_NONE;
        keep            = 1'b1;
        case (in_func)
            FN_ON:    cls.msg_type = MT_ON;
            FN_OFF:   cls.msg_type = MT_OFF;
            FN_KEYP:  cls.msg_type = MT_KEYP;
            FN_PROG:  cls.msg_type = MT_PROG;
            FN_CHANP: cls.msg_type = MT_CHANP;
            FN_BEND: begin
                cls.msg_type    = MT_BEND;
                cls.extra_value = {1'b0, in_data_two, in_data_one};
            end
            FN_CC: begin
                cls.msg_type = MT_CC;
                cls.is_cc    = 1'b1;
            end
            FN_SYS: begin
                case (in_chan)
                    SYS_SYSEX: cls.msg_type = MT_SYSEX;
                    SYS_SPP: begin
                        cls.msg_type    = MT_SPP;
                        cls.extra_value = {1'b0, in_data_two, in_data_one};
                    end
                    SYS_SSEL:  cls.msg_type = MT_SSEL;
                    SYS_CLK:   cls.msg_type = MT_CLK;
                    SYS_START: cls.msg_type = MT_START;
                    SYS_CONT:  cls.msg_type = MT_CONT;
                    SYS_STOP:  cls.msg_type = MT_STOP;
                    SYS_RESET: cls.msg_type = MT_RESET;
                    default:   keep = 1'b0;
                endcase
            end
            default: keep = 1'b0;
        endcase
    end

    assign in_ready = !clear_busy && (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/core/mcma_back.sv
// Back end: per-channel controller state, pair store and result sequencing.
module mcma_back #(
    parameter int NUM_CHANNELS  = 16,
    parameter int NUM_PAIRED_CC = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    output logic                  clear_busy,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  mcma_pkg::cmd_t        q_cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mcma_pkg::res_t        out_res,
    output logic                  out_last
);
    import mcma_pkg::*;

    localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDXW  = (NUM_PAIRED_CC > 1) ? $clog2(NUM_PAIRED_CC) : 1;
    localparam int AW    = CHW + IDXW;
    localparam int DEPTH = 1 << AW;

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    cmd_t              cur_reg, cur_next;
    res_t              res_reg [3];
    res_t              res_next [3];
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        k_reg, k_next;
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;

    logic [NUM_W-1:0]  rsel_reg  [NUM_CHANNELS];
    logic [NUM_W-1:0]  nsel_reg  [NUM_CHANNELS];
    logic [SLOT_W-1:0] emsb_reg  [NUM_CHANNELS];
    logic [SLOT_W-1:0] rpend_reg [NUM_CHANNELS];
    logic [SLOT_W-1:0] npend_reg [NUM_CHANNELS];

    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] pm;
    logic              ram_we;

    logic [CHW-1:0]    ci;
    logic              okch;
    logic [DATA_W-1:0] cc;
    logic [DATA_W-1:0] val;
    logic              is_msb, is_lsb;
    logic              armed;
    logic              comp;
    logic [NUM_W-1:0]  rs, ns, rs_n, ns_n;
    logic [SLOT_W-1:0] rp, np, em, rp_n, np_n, em_n;
    logic [NUM_W-1:0]  fv;
    logic              st_we;
    logic              pair_we;
    res_t              base;
    logic              slot_free;

    mcma_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(DEPTH)
    ) u_pair_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(pm)
    );

    assign clear_busy = (state_reg == ST_CLEAR);
    assign ram_raddr  = {q_cmd.chan[CHW-1:0], q_cmd.data_one[IDXW-1:0]};
    assign ci         = cur_reg.chan[CHW-1:0];
    assign okch       = ({1'b0, cur_reg.chan} < 5'(NUM_CHANNELS));
    assign cc         = cur_reg.data_one;
    assign val        = cur_reg.data_two;
    assign is_msb     = ({1'b0, cc} < 8'(NUM_PAIRED_CC));
    assign is_lsb     = (cc >= CC_LSB_BASE) &&
                        ({1'b0, cc} < 8'(32 + NUM_PAIRED_CC));
    assign slot_free  = !out_valid_reg || out_ready;

    always_comb begin
        rs = okch ? rsel_reg[ci]  : NUM_NONE;
        ns = okch ? nsel_reg[ci]  : NUM_NONE;
        rp = okch ? rpend_reg[ci] : SLOT_NONE;
        np = okch ? npend_reg[ci] : SLOT_NONE;
        em = okch ? emsb_reg[ci]  : SLOT_NONE;
        armed = !rs[NUM_W-1] || !ns[NUM_W-1];
        fv = em[SLOT_W-1] ? {8'd0, val} : {1'b0, em[6:0], val};

        base.msg_type     = cur_reg.msg_type;
        base.chan         = cur_reg.chan;
        base.data_one     = cur_reg.data_one;
        base.data_two     = cur_reg.data_two;
        base.param_number = NUM_NONE;
        base.extra_value  = cur_reg.extra_value;
        base.is_component = 1'b0;

        comp = 1'b0;
        if (cc >= CC_NRPN_LSB && cc <= CC_RPN_MSB) begin
            comp = 1'b1;
        end else if ((cc == CC_DATA_MSB || cc == CC_DATA_LSB) && armed) begin
            comp = 1'b1;
        end else if (cc < CC_LSB_BASE) begin
            comp = is_msb && !pm[SLOT_W-1];
        end else if (cc < CC_LSB_END) begin
            comp = is_lsb && !pm[SLOT_W-1];
        end

        rs_n = rs;
        ns_n = ns;
        rp_n = rp;
        np_n = np;
        em_n = em;
        pair_we = 1'b0;
        res_next[0] = base;
        res_next[1] = base;
        res_next[2] = base;
        res_next[1].extra_value = NUM_NONE;
        res_next[2].extra_value = NUM_NONE;
        cnt_next = 2'd1;

        if (cur_reg.is_cc) begin
            res_next[0].is_component = okch && comp;
            if (okch) begin
                if (cc == CC_RPN_MSB) begin
                    rp_n = {1'b0, val};
                end else if (cc == CC_RPN_LSB) begin
                    if (!rp[SLOT_W-1]) begin
                        res_next[1].msg_type = MT_RPN;
                        cnt_next = 2'd2;
                        rp_n = SLOT_NONE;
                        em_n = SLOT_NONE;
                        ns_n = NUM_NONE;
                        if (rp[6:0] == DATA_MAX && val == DATA_MAX) begin
                            rs_n = NUM_NONE;
                            np_n = SLOT_NONE;
                        end else begin
                            rs_n = {1'b0, rp[6:0], val};
                            res_next[1].param_number = {1'b0, rp[6:0], val};
                        end
                    end
                end else if (cc == CC_NRPN_MSB) begin
                    np_n = {1'b0, val};
                end else if (cc == CC_NRPN_LSB) begin
                    if (!np[SLOT_W-1]) begin
                        ns_n = {1'b0, np[6:0], val};
                        rs_n = NUM_NONE;
                        np_n = SLOT_NONE;
                        em_n = SLOT_NONE;
                        res_next[1].msg_type     = MT_NRPN;
                        res_next[1].param_number = {1'b0, np[6:0], val};
                        cnt_next = 2'd2;
                    end
                end else if (cc == CC_DATA_MSB && armed) begin
                    em_n = {1'b0, val};
                end else if (cc == CC_DATA_LSB && armed) begin
                    if (!rs[NUM_W-1]) begin
                        res_next[1].msg_type     = MT_RPN;
                        res_next[1].param_number = rs;
                        res_next[1].extra_value  = fv;
                        cnt_next = 2'd2;
                        if (!ns[NUM_W-1]) begin
                            res_next[2].msg_type     = MT_NRPN;
                            res_next[2].param_number = ns;
                            res_next[2].extra_value  = fv;
                            cnt_next = 2'd3;
                        end
                    end else begin
                        res_next[1].msg_type     = MT_NRPN;
                        res_next[1].param_number = ns;
                        res_next[1].extra_value  = fv;
                        cnt_next = 2'd2;
                    end
                end
                if (cc < CC_LSB_BASE) begin
                    pair_we = is_msb && (val != '0 || !pm[SLOT_W-1]);
                end else if (cc < CC_LSB_END) begin
                    if (is_lsb && !pm[SLOT_W-1]) begin
                        if (cnt_next == 2'd1) begin
                            res_next[1].msg_type     = MT_CC14;
                            res_next[1].param_number = {10'd0, cc[4:0]};
                            res_next[1].extra_value  = {1'b0, pm[6:0], val};
                            cnt_next = 2'd2;
                        end else if (cnt_next == 2'd2) begin
                            res_next[2].msg_type     = MT_CC14;
                            res_next[2].param_number = {10'd0, cc[4:0]};
                            res_next[2].extra_value  = {1'b0, pm[6:0], val};
                            cnt_next = 2'd3;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_last_next  = out_last_reg;
        q_ready        = 1'b0;
        st_we          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {ci, cc[IDXW-1:0]};
        ram_wdata      = {1'b0, val};
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = SLOT_NONE;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next   = q_cmd;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                st_we      = cur_reg.is_cc && okch;
                ram_we     = cur_reg.is_cc && pair_we;
                k_next     = 2'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_next       = res_reg[k_reg];
                    out_valid_next = 1'b1;
                    out_last_next  = (k_reg == cnt_reg - 2'd1);
                    k_next         = k_reg + 2'd1;
                    if (k_reg == cnt_reg - 2'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= 2'd0;
            cnt_reg       <= 2'd1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                rsel_reg[i]  <= NUM_NONE;
                nsel_reg[i]  <= NUM_NONE;
                emsb_reg[i]  <= SLOT_NONE;
                rpend_reg[i] <= SLOT_NONE;
                npend_reg[i] <= SLOT_NONE;
            end
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_LOOK) begin
                cnt_reg <= cnt_next;
            end
            if (st_we) begin
                rsel_reg[ci]  <= rs_n;
                nsel_reg[ci]  <= ns_n;
                emsb_reg[ci]  <= em_n;
                rpend_reg[ci] <= rp_n;
                npend_reg[ci] <= np_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (state_reg == ST_LOOK) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTH
    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (cnt_reg != 2'd0))
        else $error("result count is zero while emitting");
    a_look_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |=> (state_reg == ST_EMIT))
        else $error("lookup not followed by emission");
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !q_ready)
        else $error("queue popped during clearing pass");
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && slot_free && k_reg == 2'd0 && cnt_reg != 2'd1)
        |=> !out_last_reg)
        else $error("first of several results marked last");
`endif

endmodule

>>> tb/tb_top.sv
// Testbench for the MIDI channel message assembler with a local prediction model.
`timescale 1ns / 100ps

module tb_top;
    import mcma_pkg::*;

    typedef struct packed {
        logic [4:0]  msg_type;
        logic [3:0]  chan;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [14:0] param_number;
        logic [14:0] extra_value;
        logic        is_component;
        logic        last;
    } midi_result_t;

    localparam int NCH   = 16;
    localparam int NPAIR = 32;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    midi_result_t pending_results[$];
    midi_result_t step_outs[$];
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_off = 1'b0;

    int rpn_sel[NCH];
    int nrpn_sel[NCH];
    int entry_hi[NCH];
    int rpn_hi[NCH];
    int nrpn_hi[NCH];
    int pair_hi[NCH][NPAIR];

    midi_channel_message_assembler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("midi_channel_message_assembler verification failed");
        $finish;
    end

    task automatic clear_model();
        for (int i = 0; i < NCH; i++) begin
            rpn_sel[i] = -1;
            nrpn_sel[i] = -1;
            entry_hi[i] = -1;
            rpn_hi[i] = -1;
            nrpn_hi[i] = -1;
            for (int j = 0; j < NPAIR; j++) pair_hi[i][j] = -1;
        end
    endtask

    function automatic midi_result_t make_result(logic [4:0] mt, logic [3:0] ch, logic [6:0] d1,
                                                 logic [6:0] d2, int pnum, int xval, bit comp);
        midi_result_t r;
        r.msg_type = mt;
        r.chan = ch;
        r.data_one = d1;
        r.data_two = d2;
        r.param_number = pnum[14:0];
        r.extra_value = xval[14:0];
        r.is_component = comp;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic add_result(logic [4:0] mt, logic [3:0] ch, logic [6:0] d1, logic [6:0] d2,
                              int pnum, int xval, bit comp);
        step_outs.insert(step_outs.size(), make_result(mt, ch, d1, d2, pnum, xval, comp));
    endtask

    // classify one message and update the controller state
    task automatic assemble_message(logic [3:0] fn, logic [3:0] ch, logic [6:0] d1, logic [6:0] d2);
        int v14;
        int cc;
        int val;
        bit armed;
        bit comp;
        int num;
        int fv;
        step_outs.delete();
        v14 = d2 * 128 + d1;
        cc = d1;
        val = d2;
        comp = 1'b0;
        case (fn)
            FN_ON:    add_result(MT_ON, ch, d1, d2, -1, -1, 0);
            FN_OFF:   add_result(MT_OFF, ch, d1, d2, -1, -1, 0);
            FN_KEYP:  add_result(MT_KEYP, ch, d1, d2, -1, -1, 0);
            FN_PROG:  add_result(MT_PROG, ch, d1, d2, -1, -1, 0);
            FN_CHANP: add_result(MT_CHANP, ch, d1, d2, -1, -1, 0);
            FN_BEND:  add_result(MT_BEND, ch, d1, d2, -1, v14, 0);
            FN_SYS: begin
                case (ch)
                    SYS_SYSEX: add_result(MT_SYSEX, ch, d1, d2, -1, -1, 0);
                    SYS_SPP:   add_result(MT_SPP, ch, d1, d2, -1, v14, 0);
                    SYS_SSEL:  add_result(MT_SSEL, ch, d1, d2, -1, -1, 0);
                    SYS_CLK:   add_result(MT_CLK, ch, d1, d2, -1, -1, 0);
                    SYS_START: add_result(MT_START, ch, d1, d2, -1, -1, 0);
                    SYS_CONT:  add_result(MT_CONT, ch, d1, d2, -1, -1, 0);
                    SYS_STOP:  add_result(MT_STOP, ch, d1, d2, -1, -1, 0);
                    SYS_RESET: add_result(MT_RESET, ch, d1, d2, -1, -1, 0);
                    default: ;
                endcase
            end
            FN_CC: begin
                armed = nrpn_sel[ch] >= 0 || rpn_sel[ch] >= 0;
                if (cc >= CC_NRPN_LSB && cc <= CC_RPN_MSB) comp = 1'b1;
                else if ((cc == CC_DATA_MSB || cc == CC_DATA_LSB) && armed) comp = 1'b1;
                else if (cc < CC_LSB_BASE) comp = pair_hi[ch][cc] >= 0;
                else if (cc < CC_LSB_END) comp = pair_hi[ch][cc - CC_LSB_BASE] >= 0;
                add_result(MT_CC, ch, d1, d2, -1, -1, comp);
                if (cc == CC_RPN_MSB) begin
                    rpn_hi[ch] = val;
                end else if (cc == CC_RPN_LSB) begin
                    if (rpn_hi[ch] >= 0) begin
                        if (rpn_hi[ch] == DATA_MAX && val == DATA_MAX) begin
                            rpn_sel[ch] = -1;
                            nrpn_sel[ch] = -1;
                            nrpn_hi[ch] = -1;
                            num = -1;
                        end else begin
                            num = rpn_hi[ch] * 128 + val;
                            rpn_sel[ch] = num;
                            nrpn_sel[ch] = -1;
                        end
                        rpn_hi[ch] = -1;
                        entry_hi[ch] = -1;
                        add_result(MT_RPN, ch, d1, d2, num, -1, 0);
                    end
                end else if (cc == CC_NRPN_MSB) begin
                    nrpn_hi[ch] = val;
                end else if (cc == CC_NRPN_LSB) begin
                    if (nrpn_hi[ch] >= 0) begin
                        num = nrpn_hi[ch] * 128 + val;
                        nrpn_sel[ch] = num;
                        rpn_sel[ch] = -1;
                        nrpn_hi[ch] = -1;
                        entry_hi[ch] = -1;
                        add_result(MT_NRPN, ch, d1, d2, num, -1, 0);
                    end
                end
                armed = nrpn_sel[ch] >= 0 || rpn_sel[ch] >= 0;
                if (cc == CC_DATA_MSB && armed) begin
                    entry_hi[ch] = val;
                end else if (cc == CC_DATA_LSB && armed) begin
                    fv = entry_hi[ch] >= 0 ? entry_hi[ch] * 128 + val : val;
                    if (rpn_sel[ch] >= 0 && step_outs.size() < 3)
                        add_result(MT_RPN, ch, d1, d2, rpn_sel[ch], fv, 0);
                    if (nrpn_sel[ch] >= 0 && step_outs.size() < 3)
                        add_result(MT_NRPN, ch, d1, d2, nrpn_sel[ch], fv, 0);
                end
                if (cc < CC_LSB_BASE) begin
                    if (val > 0 || pair_hi[ch][cc] != -1) pair_hi[ch][cc] = val;
                end else if (cc < CC_LSB_END) begin
                    if (pair_hi[ch][cc - CC_LSB_BASE] >= 0 && step_outs.size() < 3)
                        add_result(MT_CC14, ch, d1, d2, cc - CC_LSB_BASE,
                                   pair_hi[ch][cc - CC_LSB_BASE] * 128 + val, 0);
                end
            end
            default: ;
        endcase
        if (step_outs.size() > 0) step_outs[step_outs.size() - 1].last = 1'b1;
        foreach (step_outs[k]) pending_results.insert(pending_results.size(), step_outs[k]);
    endtask

    task automatic send_message(logic [3:0] fn, logic [3:0] ch, logic [6:0] d1, logic [6:0] d2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        assemble_message(fn, ch, d1, d2);
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {6'b0, d2, d1, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        midi_result_t got;
        midi_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[4:0], m_tdata[3:0], m_tdata[10:4], m_tdata[17:11],
                   m_tdata[32:18], m_tdata[47:33], m_tuser[5], m_tlast};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_plain_messages();
        send_message(FN_ON, 4'h0, 7'd0, 7'd127);
        send_message(FN_OFF, 4'hF, 7'd127, 7'd0);
        send_message(FN_KEYP, 4'h5, 7'd60, 7'd64);
        send_message(FN_PROG, 4'h3, 7'd127, 7'd127);
        send_message(FN_CHANP, 4'hA, 7'd1, 7'd2);
        send_message(FN_BEND, 4'h1, 7'd127, 7'd127);
        send_message(FN_BEND, 4'h2, 7'd0, 7'd0);
        send_message(4'h3, 4'h1, 7'd5, 7'd5);
        for (int s = 0; s < 16; s++) send_message(FN_SYS, s[3:0], 7'd85, 7'd42);
    endtask

    task automatic test_controller_sequences();
        send_message(FN_CC, 4'h2, 7'd6, 7'd9);
        send_message(FN_CC, 4'h2, 7'd101, 7'd0);
        send_message(FN_CC, 4'h2, 7'd100, 7'd1);
        send_message(FN_CC, 4'h2, 7'd38, 7'd5);
        send_message(FN_CC, 4'h2, 7'd6, 7'd127);
        send_message(FN_CC, 4'h2, 7'd38, 7'd127);
        send_message(FN_CC, 4'h2, 7'd99, 7'd127);
        send_message(FN_CC, 4'h2, 7'd98, 7'd127);
        send_message(FN_CC, 4'h2, 7'd38, 7'd3);
        send_message(FN_CC, 4'h2, 7'd101, 7'd127);
        send_message(FN_CC, 4'h2, 7'd100, 7'd127);
        send_message(FN_CC, 4'h4, 7'd7, 7'd0);
        send_message(FN_CC, 4'h4, 7'd39, 7'd1);
        send_message(FN_CC, 4'h4, 7'd7, 7'd100);
        send_message(FN_CC, 4'h4, 7'd39, 7'd127);
        send_message(FN_CC, 4'h4, 7'd7, 7'd0);
        send_message(FN_CC, 4'h4, 7'd39, 7'd2);
        send_message(FN_CC, 4'h4, 7'd31, 7'd1);
        send_message(FN_CC, 4'h4, 7'd63, 7'd1);
        send_message(FN_CC, 4'h4, 7'd64, 7'd1);
    endtask

    task automatic send_random(int count);
        logic [3:0] ch;
        int pick;
        for (int i = 0; i < count; i++) begin
            ch = 4'($urandom_range(15));
            pick = $urandom_range(9);
            case (pick)
                0: send_message(4'($urandom_range(15)), 4'($urandom_range(15)),
                                7'($urandom_range(127)), 7'($urandom_range(127)));
                1, 2: begin
                    send_message(FN_CC, ch, $urandom_range(1) ? CC_RPN_MSB : CC_NRPN_MSB,
                                 $urandom_range(3) == 0 ? 7'd127 : 7'($urandom_range(127)));
                    send_message(FN_CC, ch, $urandom_range(1) ? CC_RPN_LSB : CC_NRPN_LSB,
                                 $urandom_range(3) == 0 ? 7'd127 : 7'($urandom_range(127)));
                    i++;
                end
                3, 4: send_message(FN_CC, ch, $urandom_range(1) ? CC_DATA_MSB : CC_DATA_LSB,
                                   7'($urandom_range(127)));
                5, 6: send_message(FN_CC, ch, 7'($urandom_range(63)),
                                   $urandom_range(4) == 0 ? 7'd0 : 7'($urandom_range(127)));
                7: send_message(FN_CC, ch, 7'($urandom_range(127)), 7'($urandom_range(127)));
                default: send_message(4'($urandom_range(8, 15)), ch, 7'($urandom_range(127)),
                                      7'($urandom_range(127)));
            endcase
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 29;
        recv_idle_pct = 51;
        send_random(116);
        send_idle_pct = 51;
        recv_idle_pct = 29;
        send_random(116);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(116);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                send_random(20);
                wait_drained();
            end
        join
    endtask

    initial begin
        clear_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_plain_messages();
        test_controller_sequences();
        wait_drained();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("midi_channel_message_assembler verification clean");
        end else begin
            $display("midi_channel_message_assembler verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mcma_pkg.sv
rtl/core/mcma_ram.sv
rtl/core/mcma_front.sv
rtl/core/mcma_back.sv
rtl/core/midi_channel_message_assembler.sv
tb/tb_top.sv
